// ===== rtl/mph_pkg.sv =====
// shared types, constants and helpers of the median predictor with residual histogram
// no dependencies; imported by every rtl module of the block except mph_ram
package mph_pkg;

    localparam int MPH_MAX_STRIDE = 4096;

    localparam int STRIDE_CFG_W = 13;
    localparam logic [STRIDE_CFG_W-1:0] STRIDE_RESET = 13'd1920;
    localparam logic COUNT_EN_RESET = 1'b1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_STRIDE = 1'b0;
    localparam logic REG_COUNT_EN = 1'b1;

    localparam int SAMPLE_W = 8;
    localparam int HIST_BINS = 256;
    localparam int HIST_AW = 8;
    localparam int COUNT_W = 32;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [SAMPLE_W-1:0] PRED_PLANE_START = 8'h80;

    typedef enum logic [1:0] {
        PRED_MID   = 2'd0,
        PRED_LEFT  = 2'd1,
        PRED_ABOVE = 2'd2,
        PRED_MED   = 2'd3
    } pred_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [SAMPLE_W-1:0] sample;
        logic                first_of_plane;
        logic [HIST_AW-1:0]  bin_index;
    } mph_in_t;

    typedef struct packed {
        logic                result_kind;
        logic [SAMPLE_W-1:0] residual;
        logic [COUNT_W-1:0]  bin_count;
    } mph_out_t;

    // request leaving the prediction stage toward the histogram stage
    typedef struct packed {
        logic                vld;
        logic [1:0]          cmd;
        logic [SAMPLE_W-1:0] residual;
        logic [HIST_AW-1:0]  bin;
    } mph_s1_t;

    function automatic logic [SAMPLE_W-1:0] med3(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

// ===== rtl/median_predict_with_histogram_core.sv =====
// median predictor with residual histogram, top level: config registers and stage wiring
// results are registered; one request per cycle sustained while the output is not stalled,
// set by the single histogram read-modify-write slot, forwarded between adjacent requests
// reset clears control state and config to defaults; the histogram reads zero at once
// through per-bin valid bits, so no clearing pass; the line history is undefined until written
// depends on mph_pkg, mph_predict, mph_hist
module median_predict_with_histogram_core
    import mph_pkg::*;
#(
    parameter int MAX_STRIDE = MPH_MAX_STRIDE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mph_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mph_out_t          out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [STRIDE_CFG_W-1:0] stride_reg, stride_next;
    logic                    cnt_en_reg, cnt_en_next;
    logic                    cfg_wr;
    logic                    s2_ready;
    mph_s1_t                 s1_bus;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        stride_next = stride_reg;
        cnt_en_next = cnt_en_reg;
        if (cfg_wr)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_STRIDE:   stride_next = pwdata[STRIDE_CFG_W-1:0];
                REG_COUNT_EN: cnt_en_next = pwdata[0];
                default:      stride_next = stride_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            cnt_en_reg <= COUNT_EN_RESET;
        end
        else
        begin
            stride_reg <= stride_next;
            cnt_en_reg <= cnt_en_next;
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_COUNT_EN) ? APB_DW'(cnt_en_reg) :
                                                          APB_DW'(stride_reg);

    mph_predict #(
        .MAX_STRIDE (MAX_STRIDE)
    ) u_predict (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .row_stride (stride_reg),
        .s2_ready   (s2_ready),
        .s1_bus     (s1_bus)
    );

    mph_hist u_hist (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_bus       (s1_bus),
        .count_enable (cnt_en_reg),
        .s2_ready     (s2_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // an accepted sample always lands in the prediction stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.command == CMD_PUSH) |=> s1_bus.vld)
        else $error("accepted sample did not reach the prediction stage");

    // an empty prediction stage never blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_bus.vld |-> in_ready)
        else $error("input stalled with an empty prediction stage");

    // residual results carry no count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind == KIND_RESIDUAL) |-> (out_data.bin_count == '0))
        else $error("residual result with nonzero count");

endmodule

// ===== rtl/mph_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// read-first on a same-address collision; no dependencies
module mph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mph_predict.sv =====
// prediction stage: line history ring, row tracking and residual computation
// depends on mph_pkg and mph_ram
module mph_predict
    import mph_pkg::*;
#(
    parameter int MAX_STRIDE = MPH_MAX_STRIDE
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  mph_in_t                 in_data,
    input  logic [STRIDE_CFG_W-1:0] row_stride,
    input  logic                    s2_ready,
    output mph_s1_t                 s1_bus
);

    localparam int RING_DEPTH = MAX_STRIDE + 1;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (AW > STRIDE_CFG_W) ? AW : STRIDE_CFG_W;
    localparam logic [AW:0] RING_DEPTH_X = (AW + 1)'(RING_DEPTH);

    logic [AW-1:0] stride;
    logic [CW-1:0] cfg_ext;
    logic          accept;
    logic          push;
    logic          enter;
    logic          pfr_eff;
    logic [AW-1:0] pos_eff;
    pred_t         mode;

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          pfr_reg, pfr_next;
    logic          s1_vld_reg, s1_vld_next;

    logic [SAMPLE_W-1:0] left_reg;
    logic [1:0]          s1_cmd_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [HIST_AW-1:0]  s1_bin_reg;
    pred_t               s1_mode_reg;
    logic [SAMPLE_W-1:0] s1_left_reg;

    logic [AW:0]   wr_x;
    logic [AW:0]   k_above;
    logic [AW:0]   k_al;
    logic [AW-1:0] above_addr;
    logic [AW-1:0] al_addr;

    logic [SAMPLE_W-1:0] q_above;
    logic [SAMPLE_W-1:0] q_al;
    logic [SAMPLE_W-1:0] grad;
    logic [SAMPLE_W-1:0] pred;

    // stride clamped into 1..MAX_STRIDE
    assign cfg_ext = CW'(row_stride);
    assign stride = (row_stride == '0) ? AW'(1) :
                    (cfg_ext > CW'(MAX_STRIDE)) ? AW'(MAX_STRIDE) : AW'(row_stride);

    assign in_ready = !s1_vld_reg || s2_ready;
    assign accept = in_valid && in_ready;
    assign push = accept && (in_data.command == CMD_PUSH);
    assign enter = accept && (in_data.command == CMD_PUSH || in_data.command == CMD_READ ||
                              in_data.command == CMD_CLEAR);

    assign pfr_eff = pfr_reg && !in_data.first_of_plane;
    assign pos_eff = in_data.first_of_plane ? '0 : pos_reg;

    always_comb
    begin
        mode = PRED_MID;
        pos_next = pos_reg;
        pfr_next = pfr_reg;
        if (push)
        begin
            priority if (pfr_eff)
            begin
                mode = PRED_MED;
            end
            else if (pos_eff == '0)
            begin
                mode = PRED_MID;
                pos_next = AW'(1);
                pfr_next = 1'b0;
            end
            else if (pos_eff < stride)
            begin
                mode = PRED_LEFT;
                pos_next = pos_eff + AW'(1);
                pfr_next = 1'b0;
            end
            else
            begin
                mode = PRED_ABOVE;
                pos_next = pos_eff;
                pfr_next = 1'b1;
            end
        end
    end

    // ring addresses of the sample above and the one above-left
    assign wr_x = {1'b0, wr_ptr_reg};
    assign k_above = {1'b0, stride};
    assign k_al = k_above + (AW + 1)'(1);
    assign above_addr = (wr_x >= k_above) ? AW'(wr_x - k_above) :
                                            AW'(wr_x + RING_DEPTH_X - k_above);
    assign al_addr = (wr_x >= k_al) ? AW'(wr_x - k_al) : AW'(wr_x + RING_DEPTH_X - k_al);

    assign wr_ptr_next = !push ? wr_ptr_reg :
                         (wr_ptr_reg == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);

    assign s1_vld_next = enter ? 1'b1 : (s2_ready ? 1'b0 : s1_vld_reg);

    // two copies of the ring give the two reads per sample
    mph_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_above (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (in_data.sample),
        .re    (push),
        .raddr (above_addr),
        .rdata (q_above)
    );

    mph_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_al (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (in_data.sample),
        .re    (push),
        .raddr (al_addr),
        .rdata (q_al)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            pos_reg <= '0;
            pfr_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            pos_reg <= pos_next;
            pfr_reg <= pfr_next;
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            left_reg <= in_data.sample;
        end
        if (enter)
        begin
            s1_cmd_reg <= in_data.command;
            s1_sample_reg <= in_data.sample;
            s1_bin_reg <= in_data.bin_index;
            s1_mode_reg <= mode;
            s1_left_reg <= left_reg;
        end
    end

    assign grad = q_above + s1_left_reg - q_al;

    always_comb
    begin
        unique case (s1_mode_reg)
            PRED_MID:   pred = PRED_PLANE_START;
            PRED_LEFT:  pred = s1_left_reg;
            PRED_ABOVE: pred = q_above;
            PRED_MED:   pred = med3(q_above, s1_left_reg, grad);
            default:    pred = PRED_PLANE_START;
        endcase
    end

    assign s1_bus.vld = s1_vld_reg;
    assign s1_bus.cmd = s1_cmd_reg;
    assign s1_bus.residual = s1_sample_reg - pred;
    assign s1_bus.bin = s1_bin_reg;

endmodule

// ===== rtl/mph_hist.sv =====
// histogram stage: bin read-modify-write with forwarding, valid bits, output register
// depends on mph_pkg and mph_ram
module mph_hist
    import mph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mph_s1_t  s1_bus,
    input  logic     count_enable,
    output logic     s2_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output mph_out_t out_data
);

    typedef struct packed {
        logic               wr;
        logic               clr;
        logic [HIST_AW-1:0] addr;
        logic [COUNT_W-1:0] data;
    } fwd_t;

    logic                 s2_vld_reg, s2_vld_next;
    logic [1:0]           s2_cmd_reg;
    logic [SAMPLE_W-1:0]  s2_res_reg;
    logic [HIST_AW-1:0]   s2_addr_reg;
    logic                 s2_hv_reg;
    fwd_t                 fwd_reg, fwd_next;
    logic [HIST_BINS-1:0] vld_reg, vld_next;
    logic                 ov_reg, ov_next;
    mph_out_t             od_reg, od_next;

    logic               res_item;
    logic               adv_o;
    logic               s2_fire;
    logic               take;
    logic [HIST_AW-1:0] raddr;
    logic [COUNT_W-1:0] q;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_inc;
    logic               we;
    logic               clr;

    assign res_item = (s2_cmd_reg == CMD_PUSH) || (s2_cmd_reg == CMD_READ);
    assign adv_o = !ov_reg || out_ready;
    assign s2_fire = s2_vld_reg && (!res_item || adv_o);
    assign s2_ready = !s2_vld_reg || s2_fire;
    assign take = s1_bus.vld && s2_ready;
    assign raddr = (s1_bus.cmd == CMD_PUSH) ? s1_bus.residual : s1_bus.bin;

    mph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s2_addr_reg),
        .wdata (count_inc),
        .re    (take),
        .raddr (raddr),
        .rdata (q)
    );

    // the write or clear done at the edge of our read is not in q yet
    always_comb
    begin
        priority if (fwd_reg.wr && (fwd_reg.addr == s2_addr_reg))
        begin
            count = fwd_reg.data;
        end
        else if (fwd_reg.clr)
        begin
            count = '0;
        end
        else if (s2_hv_reg)
        begin
            count = q;
        end
        else
        begin
            count = '0;
        end
    end

    assign count_inc = count + COUNT_W'(1);
    assign we = s2_fire && (s2_cmd_reg == CMD_PUSH) && count_enable;
    assign clr = s2_fire && (s2_cmd_reg == CMD_CLEAR);

    always_comb
    begin
        vld_next = vld_reg;
        if (clr)
        begin
            vld_next = '0;
        end
        else if (we)
        begin
            vld_next[s2_addr_reg] = 1'b1;
        end
    end

    always_comb
    begin
        fwd_next = fwd_reg;
        if (take)
        begin
            fwd_next.wr = we;
            fwd_next.clr = clr;
            fwd_next.addr = s2_addr_reg;
            fwd_next.data = count_inc;
        end
    end

    assign s2_vld_next = take ? 1'b1 : (s2_fire ? 1'b0 : s2_vld_reg);

    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (s2_fire && res_item)
        begin
            ov_next = 1'b1;
            if (s2_cmd_reg == CMD_PUSH)
            begin
                od_next.result_kind = KIND_RESIDUAL;
                od_next.residual = s2_res_reg;
                od_next.bin_count = '0;
            end
            else
            begin
                od_next.result_kind = KIND_COUNT;
                od_next.residual = '0;
                od_next.bin_count = count;
            end
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            fwd_reg <= '0;
            vld_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s2_vld_next;
            fwd_reg <= fwd_next;
            vld_reg <= vld_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_cmd_reg <= s1_bus.cmd;
            s2_res_reg <= s1_bus.residual;
            s2_addr_reg <= raddr;
            s2_hv_reg <= vld_reg[raddr];
        end
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

endmodule
